// ===== design/clock_offset_estimator_top_defines.svh =====
// Assertion macros used by the clock offset estimator checker
`ifndef CLOCK_OFFSET_ESTIMATOR_TOP_DEFINES_SVH
`define CLOCK_OFFSET_ESTIMATOR_TOP_DEFINES_SVH

// same-cycle implication, held off during reset
`define COE_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("clock offset estimator: assertion failed");

// next-cycle implication, held off during reset
`define COE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("clock offset estimator: assertion failed");

`endif

// ===== design/coe_pkg.sv =====
// Types and constants of the clock offset estimator
package coe_pkg;

    localparam int IN_W      = 63;
    localparam int OFF_W     = 64;
    localparam int LIMIT_W   = 30;
    localparam int FACTOR_W  = 4;
    localparam int CFG_A_W   = 2;
    // window sums with one fractional bit, up to 512 samples, plus sign
    localparam int ACC_W     = 74;
    localparam int DCNT_W    = $clog2(ACC_W + 1);
    localparam int PROD_W    = ACC_W + FACTOR_W + 1;

    localparam logic [CFG_A_W-1:0] REG_LIMIT  = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_FACTOR = 2'd1;

    localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 30'd20000000;
    localparam logic [FACTOR_W-1:0] FACTOR_RST = 4'd3;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic mem_wr;
        logic acc_clr;
        logic acc_rt;
        logic acc_d;
        logic div_start;
        logic div_mean;
        logic take_mean;
        logic off_load;
        logic upd_off;
        logic full;
        logic out_load;
        logic out_acc;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic reject;
    } sts_t;

endpackage

// ===== design/coe_ctrl.sv =====
// Sequencer of the clock offset estimator: sweeps, divides and result hand-off
module coe_ctrl #(
    parameter int W  = 16,
    parameter int AW = 4,
    parameter int CW = 5
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  coe_pkg::sts_t sts,
    output coe_pkg::cmd_t cmd,
    output logic [AW-1:0] addr,
    output logic [CW-1:0] fill
);
    import coe_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_FWR  = 4'd1;
    localparam logic [3:0] S_RSWP = 4'd2;
    localparam logic [3:0] S_DIVM = 4'd3;
    localparam logic [3:0] S_MUL  = 4'd4;
    localparam logic [3:0] S_CMP  = 4'd5;
    localparam logic [3:0] S_DSWP = 4'd6;
    localparam logic [3:0] S_DIVO = 4'd7;
    localparam logic [3:0] S_OFFS = 4'd8;
    localparam logic [3:0] S_UPD  = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;
    localparam logic [3:0] S_REJ  = 4'd11;
    localparam logic [3:0] S_RDIV = 4'd12;
    localparam logic [3:0] S_ODIV = 4'd13;

    localparam logic [CW-1:0] FULL_N = CW'(W);
    localparam logic [AW-1:0] WP_MAX = AW'(W - 1);

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          mv_reg, mv_next;
    logic          out_free;

    assign out_free = !mv_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mv_reg;
    assign fill     = fill_reg;

    // next state and command decode
    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        wp_next    = wp_reg;
        cnt_next   = cnt_reg;
        mv_next    = mv_reg && !m_tready;
        cmd        = '0;
        cmd.full   = (fill_reg == FULL_N);
        addr       = cnt_reg[AW-1:0];
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    cmd.acc_clr = 1'b1;
                    cnt_next    = '0;
                    state_next  = (fill_reg == FULL_N) ? S_RSWP : S_FWR;
                end
            end
            S_FWR: begin
                addr       = fill_reg[AW-1:0];
                cmd.mem_wr = 1'b1;
                fill_next  = fill_reg + 1'b1;
                state_next = S_DSWP;
            end
            S_RSWP: begin
                cmd.acc_rt = (cnt_reg != '0);
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == FULL_N) begin
                    state_next = S_RDIV;
                end
            end
            // last round trip is in the accumulator now
            S_RDIV: begin
                cmd.div_start = 1'b1;
                cmd.div_mean  = 1'b1;
                state_next    = S_DIVM;
            end
            S_DIVM: begin
                if (sts.div_done) begin
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                cmd.take_mean = 1'b1;
                state_next    = S_CMP;
            end
            S_CMP: begin
                if (sts.reject) begin
                    state_next = S_REJ;
                end else begin
                    addr        = wp_reg;
                    cmd.mem_wr  = 1'b1;
                    cmd.acc_clr = 1'b1;
                    cnt_next    = '0;
                    wp_next     = (wp_reg == WP_MAX) ? '0 : wp_reg + 1'b1;
                    state_next  = S_DSWP;
                end
            end
            S_DSWP: begin
                cmd.acc_d = (cnt_reg != '0);
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == fill_reg) begin
                    state_next = S_ODIV;
                end
            end
            // last offset term is in the accumulator now
            S_ODIV: begin
                cmd.div_start = 1'b1;
                state_next    = S_DIVO;
            end
            S_DIVO: begin
                if (sts.div_done) begin
                    state_next = S_OFFS;
                end
            end
            S_OFFS: begin
                cmd.off_load = 1'b1;
                state_next   = S_UPD;
            end
            S_UPD: begin
                cmd.upd_off = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT, S_REJ: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_acc  = (state_reg == S_OUT);
                    mv_next      = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            wp_reg    <= '0;
            cnt_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            wp_reg    <= wp_next;
            cnt_reg   <= cnt_next;
            mv_reg    <= mv_next;
        end
    end

endmodule

// ===== design/coe_dp.sv =====
// Datapath: sample memories, window accumulator, serial divider, offset and result registers
module coe_dp #(
    parameter int W  = 16,
    parameter int AW = 4,
    parameter int CW = 5
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [coe_pkg::CFG_A_W-1:0]    cfg_addr,
    input  logic [coe_pkg::LIMIT_W-1:0]    cfg_wdata,
    input  logic [coe_pkg::IN_W-1:0]       query_time,
    input  logic [coe_pkg::IN_W-1:0]       response_time,
    input  logic [coe_pkg::IN_W-1:0]       received_time,
    input  coe_pkg::cmd_t                  cmd,
    input  logic [AW-1:0]                  addr,
    input  logic [CW-1:0]                  fill,
    output coe_pkg::sts_t                  sts,
    output logic [coe_pkg::OFF_W-1:0]      offset_word,
    output logic                           stable,
    output logic                           accepted
);
    import coe_pkg::*;

    localparam int DVW = CW + 1;

    logic [LIMIT_W-1:0]  limit_reg;
    logic [FACTOR_W-1:0] factor_reg;
    logic [IN_W-1:0]     q_in_reg, r_in_reg, c_in_reg;
    logic [IN_W-1:0]     q_mem [W];
    logic [IN_W-1:0]     r_mem [W];
    logic [IN_W-1:0]     c_mem [W];
    logic [IN_W-1:0]     q_rd_reg, r_rd_reg, c_rd_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [ACC_W-1:0]    quo_reg;
    logic [DVW-1:0]      rem_reg, dvs_reg;
    logic [DCNT_W-1:0]   dcnt_reg;
    logic                neg_reg;
    logic [DVW:0]        trial;
    logic                ge;
    logic [ACC_W-1:0]    q_signed;
    logic [PROD_W-1:0]   prod_reg;
    logic [PROD_W-1:0]   rt_ext;
    logic [ACC_W-1:0]    off_reg;
    logic [OFF_W-1:0]    cur_reg;
    logic [ACC_W:0]      diff, diff_abs;
    logic                is_stable;
    logic [OFF_W-1:0]    out_off_reg;
    logic                out_acc_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg  <= LIMIT_RST;
            factor_reg <= FACTOR_RST;
        end else if (cfg_we) begin
            if (cfg_addr == REG_LIMIT)  limit_reg  <= cfg_wdata;
            if (cfg_addr == REG_FACTOR) factor_reg <= cfg_wdata[FACTOR_W-1:0];
        end
    end

    // captured input word
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            q_in_reg <= query_time;
            r_in_reg <= response_time;
            c_in_reg <= received_time;
        end
    end

    // sample memories, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (cmd.mem_wr) begin
            q_mem[addr] <= q_in_reg;
            r_mem[addr] <= r_in_reg;
            c_mem[addr] <= c_in_reg;
        end
        q_rd_reg <= q_mem[addr];
        r_rd_reg <= r_mem[addr];
        c_rd_reg <= c_mem[addr];
    end

    // window accumulator: round trips (received - query) or 2 response - query - received terms
    always_ff @(posedge aclk) begin
        if (cmd.acc_clr) begin
            acc_reg <= '0;
        end else if (cmd.acc_rt) begin
            acc_reg <= acc_reg + ACC_W'(c_rd_reg) - ACC_W'(q_rd_reg);
        end else if (cmd.acc_d) begin
            acc_reg <= acc_reg + ACC_W'({r_rd_reg, 1'b0})
                       - ACC_W'(q_rd_reg) - ACC_W'(c_rd_reg);
        end
    end

    // restoring divider on the magnitude, one quotient bit a cycle
    assign trial    = {rem_reg, quo_reg[ACC_W-1]};
    assign ge       = (trial >= {1'b0, dvs_reg});
    assign q_signed = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign sts.div_done = (dcnt_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dcnt_reg <= '0;
        end else if (cmd.div_start) begin
            dcnt_reg <= DCNT_W'(ACC_W);
        end else if (dcnt_reg != '0) begin
            dcnt_reg <= dcnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            neg_reg <= acc_reg[ACC_W-1];
            quo_reg <= acc_reg[ACC_W-1] ? (~acc_reg + 1'b1) : acc_reg;
            rem_reg <= '0;
            dvs_reg <= cmd.div_mean ? DVW'(W) : {fill, 1'b0};
        end else if (dcnt_reg != '0) begin
            rem_reg <= ge ? DVW'(trial - {1'b0, dvs_reg}) : trial[DVW-1:0];
            quo_reg <= {quo_reg[ACC_W-2:0], ge};
        end
    end

    // outlier threshold and test; times are unsigned, the round trip is signed
    assign rt_ext     = PROD_W'($signed({1'b0, c_in_reg}) - $signed({1'b0, q_in_reg}));
    assign sts.reject = ($signed(prod_reg) < $signed(rt_ext));

    always_ff @(posedge aclk) begin
        if (cmd.take_mean) begin
            prod_reg <= PROD_W'($signed(q_signed) * $signed({1'b0, factor_reg}));
        end
    end

    // offset and stability
    assign diff      = {off_reg[ACC_W-1], off_reg}
                       - {{(ACC_W+1-OFF_W){cur_reg[OFF_W-1]}}, cur_reg};
    assign diff_abs  = diff[ACC_W] ? (~diff + 1'b1) : diff;
    assign is_stable = (diff_abs < (ACC_W+1)'(limit_reg));

    always_ff @(posedge aclk) begin
        if (cmd.off_load) off_reg <= q_signed;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg <= '0;
        end else if (cmd.upd_off) begin
            cur_reg <= {off_reg[OFF_W-1:1], cmd.full && is_stable};
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_off_reg <= cur_reg;
            out_acc_reg <= cmd.out_acc;
        end
    end

    assign offset_word = out_off_reg;
    assign stable      = out_off_reg[0];
    assign accepted    = out_acc_reg;

endmodule

// ===== design/clock_offset_estimator_top.sv =====
// Top level of the clock offset estimator
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  s_tdata: query, response, received times
//  m_       out  m_tvalid/m_tready  m_tdata: offset word; m_tuser: stable, accepted
//  cfg_     in   cfg_we             cfg_addr selects limit (0) or factor (1)
//
// While filling, a sample gets a memory write, an offset sweep over the stored
// samples, a serial divide and hand-off. Once full it gets the round-trip sweep
// and divide, then the offset sweep and divide; a rejected sample ends after the
// first divide. Reset is synchronous; no memory clearing is needed. The block
// returns to idle once the result register is loaded; a stalled result holds the
// next item only.
module clock_offset_estimator_top #(
    parameter int WINDOW_SIZE = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // query_time[62:0], response_time[125:63], received_time[188:126], zero pad
    input  logic [191:0]                s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // offset_word[63:0]
    output logic [63:0]                 m_tdata,
    // stable[0], accepted[1]
    output logic [1:0]                  m_tuser,
    input  logic                        cfg_we,
    input  logic [coe_pkg::CFG_A_W-1:0] cfg_addr,
    input  logic [coe_pkg::LIMIT_W-1:0] cfg_wdata
);
    import coe_pkg::*;

    localparam int AW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int CW = $clog2(WINDOW_SIZE + 1);

    cmd_t          cmd;
    sts_t          sts;
    logic [AW-1:0] addr;
    logic [CW-1:0] fill;

    coe_ctrl #(.W(WINDOW_SIZE), .AW(AW), .CW(CW)) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd),
        .addr     (addr),
        .fill     (fill)
    );

    coe_dp #(.W(WINDOW_SIZE), .AW(AW), .CW(CW)) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .query_time    (s_tdata[62:0]),
        .response_time (s_tdata[125:63]),
        .received_time (s_tdata[188:126]),
        .cmd           (cmd),
        .addr          (addr),
        .fill          (fill),
        .sts           (sts),
        .offset_word   (m_tdata),
        .stable        (m_tuser[0]),
        .accepted      (m_tuser[1])
    );

endmodule

// ===== design/coe_checker.sv =====
// Port-level checker for the clock offset estimator, with its bind
`include "clock_offset_estimator_top_defines.svh"

module coe_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [1:0]  m_tuser
);
    // a waiting result stays offered
    `COE_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    // one word in flight: busy right after an accept
    `COE_ASSERT_NEXT(a_busy_after_in, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // stable flag mirrors bit 0 of the offset word
    `COE_ASSERT_NOW(a_flag_bit, aclk, aresetn, m_tvalid, m_tuser[0] == m_tdata[0])
    // a fresh result appears as the block goes back to idle
    `COE_ASSERT_NOW(a_new_word_at_idle, aclk, aresetn, $rose(m_tvalid), s_tready)
endmodule

bind clock_offset_estimator_top coe_checker u_coe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
